/* rtl/tkxc_pkg.sv */
// package for the table keystream xor cipher unit
// holds sequencer state type, field widths, register codes and the seed byte function
// no dependencies
package tkxc_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = 7;
  localparam logic [IDX_W-1:0] PTR_SLOT = 7'd127;

  // field and register widths
  localparam int LEN_W     = 31;
  localparam int BYTE_W    = 8;
  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 4;
  localparam int WARM_W    = 12;
  localparam int S_TDATA_W = 40;

  // register reset values
  localparam logic [KEY_W-1:0]  KEY_RESET     = 64'h0000_0000_6576_616C;
  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 4'd4;

  // configuration register indexes
  localparam logic CFG_KEY_BYTES  = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  // item kinds carried on tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_UPD
  } tkxc_state_t;

  // value a table entry holds right after seeding, before any keystream write
  function automatic logic [BYTE_W-1:0] seed_byte(
    input logic [LEN_W-1:0]  len,
    input logic [KEY_W-1:0]  key,
    input logic [KLEN_W-1:0] klen,
    input logic [IDX_W-1:0]  idx
  );
    logic [BYTE_W-1:0] len_byte;
    logic [BYTE_W-1:0] key_byte;
    case (idx[1:0])
      2'd0:    len_byte = len[7:0];
      2'd1:    len_byte = len[15:8];
      2'd2:    len_byte = len[23:16];
      default: len_byte = {1'b0, len[30:24]};
    endcase
    key_byte = key[{idx[2:0], 3'b000} +: BYTE_W];
    if (idx < {3'b000, klen}) begin
      return len_byte ^ key_byte;
    end
    return len_byte;
  endfunction

endpackage

/* rtl/table_keystream_xor_cipher_unit.sv */
// top level of the table keystream xor cipher unit
// depends on tkxc_pkg and tkxc_ram

// Byte stream cipher over a 128-entry table whose last entry is the walk pointer. A start
// transaction (tuser = 0) reseeds the table from its 31-bit length and the configured key and
// then runs WARMUP_STEPS discarded keystream steps; it yields no output and holds off further
// input until the last step is done. A data transaction (tuser = 1) returns its byte XOR the
// next keystream byte; no new transaction is accepted until it has passed ST_MIX and ST_UPD.
// Each keystream step makes two dependent passes through one shared 8-bit adder, with the table
// memory's registered read port between them. Reseeding needs no clearing pass: per-entry
// valid bits are all cleared when the start is accepted and an entry not yet written reads as
// its seed value. A new transaction is accepted while a result still waits; the block only
// waits on the output side when a second result is ready before the first is taken.
module table_keystream_xor_cipher_unit
  import tkxc_pkg::*;
#(
  parameter int WARMUP_STEPS  = 2048,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // length[30:0], data_byte[38:31], zero[39]
  input  logic                 s_tuser,   // action[0]
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // out_byte[7:0]
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  // configuration registers
  logic [KEY_W-1:0]  key_bytes;
  logic [KLEN_W-1:0] key_length;
  logic [KLEN_W-1:0] klen_clamped;

  // seed snapshot taken at start
  logic [LEN_W-1:0]  seed_len;
  logic [KEY_W-1:0]  seed_key;
  logic [KLEN_W-1:0] seed_klen;

  // walk state: pointer and the table entry it points at
  logic [IDX_W-1:0]  ptr;
  logic [BYTE_W-1:0] head_val;
  logic [IDX_W-1:0]  nptr;
  logic [IDX_W-1:0]  nptr_calc;
  logic [TABLE_DEPTH-1:0] valid;

  // item and sequencing registers
  tkxc_state_t       state, state_next;
  logic              is_data;
  logic [BYTE_W-1:0] data_byte;
  logic [WARM_W-1:0] warm_cnt;

  // shared adder
  logic [BYTE_W-1:0] add_a;
  logic [BYTE_W-1:0] add_b;
  logic              add_c;
  logic [BYTE_W-1:0] add_sum;

  // table memory
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] entry_val;

  // control
  logic in_fire;
  logic start_fire;
  logic commit;
  logic warm_done;
  logic out_load;

  logic [LEN_W-1:0]  in_len;
  logic [IDX_W-1:0]  start_ptr;

  assign in_len     = s_tdata[LEN_W-1:0];
  assign start_ptr  = in_len[LEN_W-1 -: IDX_W];
  assign s_tready   = (state == ST_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign start_fire = in_fire && (s_tuser == ACT_START);
  assign warm_done  = (warm_cnt == WARM_W'(WARMUP_STEPS - 1));

  assign klen_clamped = (key_length > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES)
                                                               : key_length;

  // entry at the new pointer: memory if written since seeding, else its seed value
  assign entry_val = valid[nptr] ? ram_rdata : seed_byte(seed_len, seed_key, seed_klen, nptr);

  // operand select for the shared adder
  always_comb begin
    if (state == ST_UPD) begin
      add_a = entry_val;
      add_b = {1'b0, ptr};
      add_c = 1'b1;
    end else begin
      add_a = {1'b0, ptr};
      add_b = head_val;
      add_c = 1'b0;
    end
  end

  assign add_sum   = add_a + add_b + {{(BYTE_W-1){1'b0}}, add_c};
  assign nptr_calc = (add_sum[IDX_W-1:0] == PTR_SLOT) ? '0 : add_sum[IDX_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    commit     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_tuser == ACT_DATA || WARMUP_STEPS != 0) begin
            state_next = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        ram_re     = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (is_data) begin
          if (!m_tvalid || m_tready) begin
            commit     = 1'b1;
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          commit     = 1'b1;
          state_next = warm_done ? ST_IDLE : ST_MIX;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ram_we = commit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= KEY_RESET;
      key_length <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_BYTES:  key_bytes  <= cfg_data;
        CFG_KEY_LENGTH: key_length <= cfg_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // walk state, seed snapshot and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      head_val  <= '0;
      valid     <= '0;
      seed_len  <= '0;
      seed_key  <= '0;
      seed_klen <= '0;
      warm_cnt  <= '0;
    end else begin
      if (start_fire) begin
        seed_len  <= in_len;
        seed_key  <= key_bytes;
        seed_klen <= klen_clamped;
        valid     <= '0;
        ptr       <= start_ptr;
        head_val  <= (start_ptr == PTR_SLOT) ? {1'b0, PTR_SLOT}
                     : seed_byte(in_len, key_bytes, klen_clamped, start_ptr);
        warm_cnt  <= '0;
      end
      if (commit) begin
        ptr         <= nptr;
        head_val    <= add_sum;
        valid[nptr] <= 1'b1;
        if (!is_data) begin
          warm_cnt <= warm_done ? '0 : warm_cnt + WARM_W'(1);
        end
      end
    end
  end

  // item capture and new pointer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_data   <= (s_tuser == ACT_DATA);
      data_byte <= s_tdata[LEN_W +: BYTE_W];
    end
    if (state == ST_MIX) begin
      nptr <= nptr_calc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= data_byte ^ add_sum;
    end
  end

  // mixing table
  tkxc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nptr),
    .wdata (add_sum),
    .re    (ram_re),
    .raddr (nptr_calc),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // the pointer slot is never written through the memory
  a_no_ptr_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (nptr != PTR_SLOT))
    else $error("table write aimed at the pointer slot");

  // after a keystream step the pointer never rests on the pointer slot
  a_ptr_after_step: assert property (@(posedge clk) disable iff (rst)
    commit |=> (ptr != PTR_SLOT))
    else $error("pointer left on slot 127 after a step");

  // a start transaction wipes every written mark
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> (valid == '0))
    else $error("valid bits not cleared by start");

  // warm-up counter is back at zero whenever the block is idle
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (warm_cnt == '0))
    else $error("warm-up count nonzero while idle");

  // a result is only loaded on a data transaction
  a_load_data: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (is_data && state == ST_UPD))
    else $error("result loaded outside a data step");
`endif

endmodule

/* rtl/tkxc_ram.sv */
// generic single write port, single read port ram with registered read data
// used for the mixing table; no dependencies
module tkxc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* verif/tb.sv */
// self-checking testbench for table_keystream_xor_cipher_unit
// keeps its own copy of the 128-byte table and key to predict every output byte
// depends on tkxc_pkg and the rtl of the unit

module tb
  import tkxc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WARMUP_STEPS   = 2048;
  localparam int KEY_BYTES_MAX  = 8;
  // a start stays busy through WARMUP_STEPS keystream steps, so settle a little beyond that
  localparam int SETTLE_CYCLES  = 4200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 125;

  // predictor and store of expected output bytes
  class cipher_scoreboard;
    logic [BYTE_W-1:0] mix_table [TABLE_DEPTH];
    logic [KEY_W-1:0]  key_bytes;
    logic [KLEN_W-1:0] key_length;
    logic [BYTE_W-1:0] expected_bytes [$];
    int errors;
    int items_in;
    int reseeds;
    int bytes_checked;

    function new();
      foreach (mix_table[i]) mix_table[i] = '0;
      key_bytes     = KEY_RESET;
      key_length    = KEY_LEN_RESET;
      errors        = 0;
      items_in      = 0;
      reseeds       = 0;
      bytes_checked = 0;
    endfunction

    // one walk of the pointer, returns the updated entry
    function logic [BYTE_W-1:0] keystream_step();
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] np;
      p  = mix_table[PTR_SLOT][IDX_W-1:0];
      np = p + mix_table[p][IDX_W-1:0];
      if (np == PTR_SLOT) np = '0;
      mix_table[PTR_SLOT] = {1'b0, np};
      mix_table[np] = mix_table[np] + {1'b0, p} + 8'd1;
      return mix_table[np];
    endfunction

    // fill from the length word, fold in the key, then discard the warm-up bytes
    function void reseed(logic [LEN_W-1:0] len);
      logic [31:0] word;
      int klen;
      word = {1'b0, len};
      klen = (key_length > KEY_BYTES_MAX) ? KEY_BYTES_MAX : key_length;
      for (int i = 0; i < TABLE_DEPTH; i++) mix_table[i] = word[8*(i%4) +: 8];
      for (int i = 0; i < klen; i++) mix_table[i] = mix_table[i] ^ key_bytes[8*i +: 8];
      mix_table[PTR_SLOT] = mix_table[PTR_SLOT] & 8'h7f;
      repeat (WARMUP_STEPS) void'(keystream_step());
      reseeds++;
    endfunction

    function void note_item(logic act, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] dat);
      items_in++;
      if (act == ACT_START) begin
        reseed(len);
      end else begin
        expected_bytes.push_back(dat ^ keystream_step());
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected out_byte, expected none, actual %02h", $time, got);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got !== want) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // length[30:0], data_byte[38:31], zero[39]
  logic                 s_tuser;   // action[0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [BYTE_W-1:0]    m_tdata;   // out_byte[7:0]
  logic                 cfg_we;
  logic                 cfg_index;
  logic [KEY_W-1:0]     cfg_data;

  cipher_scoreboard sb;
  bit steady;
  int idle_cycles;
  int settings_used;

  table_keystream_xor_cipher_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        idle_cycles = 0;
      end
      if (s_tvalid && s_tready) begin
        sb.note_item(s_tuser, s_tdata[LEN_W-1:0], s_tdata[LEN_W +: BYTE_W]);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // output side back-pressure
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // present one item and wait for its transaction
  task automatic send_item(logic act, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] dat);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, dat, len};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending until every expected byte has come out
  task automatic hold_off();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [KEY_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_KEY_BYTES) sb.key_bytes = val;
    else sb.key_length = val[KLEN_W-1:0];
  endtask

  // new key setting, only once the unit has finished any warm-up
  task automatic apply_setting(logic [KEY_W-1:0] key, logic [KLEN_W-1:0] klen);
    hold_off();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_KEY_BYTES, key);
    write_reg(CFG_KEY_LENGTH, KEY_W'(klen));
    settings_used++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] len;
    int r;
    len = LEN_W'($urandom);
    r = $urandom_range(0, 9);
    // short messages, and top byte 0x7f so the pointer starts on its own slot
    if (r < 2) len = LEN_W'($urandom_range(0, 300));
    else if (r == 2) len[30:24] = 7'h7f;
    return len;
  endfunction

  // messages of a start and its data bytes, with some stray and broken sequences
  task automatic run_messages(int n_items);
    int sent;
    logic act;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) steady = !steady;
      if ($urandom_range(0, 99) < 8) hold_off();
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4)) begin
          act = ($urandom_range(0, 5) == 0) ? ACT_START : ACT_DATA;
          send_item(act, LEN_W'($urandom), BYTE_W'($urandom));
          sent++;
        end
      end else begin
        send_item(ACT_START, pick_length(), BYTE_W'($urandom));
        sent++;
        repeat ($urandom_range(2, 25)) begin
          send_item(ACT_DATA, LEN_W'($urandom), BYTE_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb            = new();
    steady        = 1'b0;
    idle_cycles   = 0;
    settings_used = 1;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tuser       = ACT_START;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_KEY_BYTES;
    cfg_data      = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // data on the cleared table, before any start
    send_item(ACT_DATA, '0, 8'h00);
    send_item(ACT_DATA, '1, 8'hff);
    send_item(ACT_DATA, '0, 8'ha5);
    // extreme lengths
    send_item(ACT_START, '0, 8'hff);
    send_item(ACT_DATA, '0, 8'h00);
    send_item(ACT_DATA, '0, 8'hff);
    send_item(ACT_START, 31'h7fff_ffff, 8'h00);
    send_item(ACT_DATA, 31'h7fff_ffff, 8'h00);
    send_item(ACT_DATA, '0, 8'hff);
    send_item(ACT_DATA, '0, 8'h3c);
    // pointer left on its own slot after seeding
    send_item(ACT_START, 31'h7f00_0000, 8'h00);
    send_item(ACT_DATA, '0, 8'h5a);
    send_item(ACT_DATA, '0, 8'hc3);
    send_item(ACT_START, 31'h7f55_aa01, 8'h00);
    send_item(ACT_DATA, '0, 8'h81);
    // two starts back to back
    send_item(ACT_START, 31'h2aaa_aaaa, 8'h00);
    send_item(ACT_START, 31'h5555_5555, 8'h00);
    send_item(ACT_DATA, '0, 8'h7e);
    send_item(ACT_DATA, '0, 8'h01);
    hold_off();

    // reset key, then a sweep of key settings
    run_messages(PHASE_ITEMS);
    apply_setting(64'hffff_ffff_ffff_ffff, 4'd8);
    run_messages(PHASE_ITEMS);
    apply_setting({$urandom, $urandom}, 4'd0);
    run_messages(PHASE_ITEMS);
    // zero bytes inside the counted key
    apply_setting(64'h0011_0000_2200_0033, 4'd8);
    run_messages(PHASE_ITEMS);
    // key lengths beyond the limit
    apply_setting({$urandom, $urandom}, 4'd15);
    run_messages(PHASE_ITEMS);
    apply_setting({$urandom, $urandom}, 4'd9);
    run_messages(PHASE_ITEMS);
    apply_setting('0, 4'd8);
    run_messages(PHASE_ITEMS);
    apply_setting({$urandom, $urandom}, KLEN_W'($urandom_range(0, 15)));
    run_messages(PHASE_ITEMS);
    apply_setting(KEY_RESET, KEY_LEN_RESET);
    run_messages(PHASE_ITEMS);

    // drain, then give a last warm-up time to show up any stray output
    hold_off();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d input transactions with %0d reseeds under %0d key settings",
             sb.items_in, sb.reseeds, settings_used);
    $display("%0d output bytes checked, %0d errors", sb.bytes_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
